// File: rtl/sa_pkg.sv
// Shared constants, codes and types of the slot allocator.
`default_nettype none

package sa_pkg;

    // Slot store geometry.
    localparam int NUM_SLOTS = 4096;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int ROW_W     = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
    localparam int BIT_W     = $clog2(ROW_W);
    localparam int ROWS      = NUM_SLOTS / ROW_W;
    localparam int ROW_IDX_W = SLOT_W - BIT_W;

    // Field widths of the request and response words.
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 41;
    localparam int TYPE_W    = 8;
    localparam int BLOB_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int OUT_POS_W = 33;
    localparam int CNT_W     = 13;

    // Object size register and the arithmetic built on it.
    localparam int SZ_W                 = 21;
    localparam logic [SZ_W-1:0] SZ_MAX  = SZ_W'(1048576);
    localparam int MUL_W                = CNT_W + SZ_W;
    localparam int DVD_W                = SLOT_W + SZ_W;
    localparam int DIV_CNT_W            = $clog2(SLOT_W);

    // Configuration port.
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_SLOT_BYTES = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REF_TYPE   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_REF_BLOB   = 2'd3;

    localparam logic [SZ_W-1:0] SLOT_BYTES_RST = SZ_W'(4096);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_FIND    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TEST    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Register file contents.
    typedef struct packed {
        logic [SZ_W-1:0]   slot_bytes;
        logic [CNT_W-1:0]  slot_limit;
        logic [TYPE_W-1:0] ref_type;
        logic [BLOB_W-1:0] ref_blob;
    } t_cfg;

    // Divider result towards the sequencer.
    typedef struct packed {
        logic              done;
        logic              exact;
        logic [SLOT_W-1:0] quot;
    } t_div_res;

endpackage

`default_nettype wire

// File: rtl/sa_if.sv
// Request and response channel interfaces of the slot allocator.
`default_nettype none

interface sa_req_if;
    logic                             valid;
    logic                             ready;
    logic [sa_pkg::FUNC_W-1:0]        func;
    logic signed [sa_pkg::POS_W-1:0]  position;
    logic [sa_pkg::TYPE_W-1:0]        obj_type;
    logic [sa_pkg::BLOB_W-1:0]        blob_id;

    modport source (output valid, func, position, obj_type, blob_id, input ready);
    modport sink   (input valid, func, position, obj_type, blob_id, output ready);
endinterface

interface sa_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [sa_pkg::STATUS_W-1:0]          status;
    logic signed [sa_pkg::OUT_POS_W-1:0]  found_position;
    logic [sa_pkg::CNT_W-1:0]             used_count;

    modport source (output valid, status, found_position, used_count, input ready);
    modport sink   (input valid, status, found_position, used_count, output ready);
endinterface

`default_nettype wire

// File: rtl/slot_allocator_with_state_map_core.sv
// Top level of the slot allocator: sequencer, used map store and result register.
//
//  Channel   Direction  Handshake             Word
//  i_req     in         valid/ready           func, position, obj_type, blob_id
//  o_rsp     out        valid/ready           status, found_position, used_count
//  APB       in/out     psel/penable/pready   64-bit register data, paddr[4:3] index
//
// One request is in work at a time; the used map is kept as 32-slot rows in one RAM.
// Test, allocate and release turn the position into a slot in the 12-step bit-serial
// divider; a request failing the type, id or range check skips it, a misaligned one is
// rejected after it. Find free reads a map row and then checks it, row by row, up to
// 129 rows when the scan wraps.
// After reset a clearing pass writes all 128 rows before the first word
// is accepted. A stalled result word waits in the output register; a new word is
// accepted meanwhile and its result is held back until the register is free.
`default_nettype none

module slot_allocator_with_state_map_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    sa_req_if.sink                          i_req,
    sa_rsp_if.source                        o_rsp,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sa_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sa_pkg::PDATA_W-1:0] pwdata,
    output logic [sa_pkg::PDATA_W-1:0]      prdata,
    output logic                            pready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_RANGE,
        S_DIV,
        S_RD,
        S_MOD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FMUL,
        S_FPOS,
        S_RESP
    } t_state;

    t_state                            r_state;
    sa_pkg::t_cfg                      cfg;
    sa_pkg::t_div_res                  div_res;

    logic [sa_pkg::FUNC_W-1:0]         r_func;
    logic [sa_pkg::POS_W-1:0]          r_position;
    logic [sa_pkg::TYPE_W-1:0]         r_obj_type;
    logic [sa_pkg::BLOB_W-1:0]         r_blob_id;
    logic [sa_pkg::CNT_W-1:0]          r_count;
    logic [sa_pkg::SLOT_W-1:0]         r_slot;
    logic [sa_pkg::ROW_IDX_W-1:0]      r_row;
    logic [sa_pkg::CNT_W-1:0]          r_lo;
    logic [sa_pkg::CNT_W-1:0]          r_hi;
    logic                              r_pass;
    logic [sa_pkg::MUL_W-1:0]          r_prod;
    logic [sa_pkg::STATUS_W-1:0]       r_status;
    logic [sa_pkg::OUT_POS_W-1:0]      r_fpos;
    logic                              r_out_valid;
    logic [sa_pkg::STATUS_W-1:0]       r_out_status;
    logic [sa_pkg::OUT_POS_W-1:0]      r_out_pos;
    logic [sa_pkg::CNT_W-1:0]          r_out_count;

    logic [sa_pkg::CNT_W-1:0]          eff_lim;
    logic [sa_pkg::SZ_W-1:0]           eff_sz;
    logic [sa_pkg::CNT_W-1:0]          mul_a;
    logic                              req_ok;
    logic                              div_start;

    logic                              ram_we;
    logic [sa_pkg::ROW_IDX_W-1:0]      ram_addr;
    logic [sa_pkg::ROW_W-1:0]          ram_wdata;
    logic [sa_pkg::ROW_W-1:0]          ram_rdata;

    logic [sa_pkg::ROW_W-1:0]          free_m;
    logic [sa_pkg::ROW_W-1:0]          free_iso;
    logic [sa_pkg::BIT_W-1:0]          hit_idx;
    logic                              scan_hit;
    logic                              scan_last;

    logic                              cur_bit;
    logic                              mod_write;
    logic [sa_pkg::STATUS_W-1:0]       mod_status;
    logic [sa_pkg::ROW_W-1:0]          mod_row;
    logic [sa_pkg::CNT_W-1:0]          n_count;

    // Configuration registers.
    sa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Oversized register values act as their maxima.
    assign eff_lim = (cfg.slot_limit > sa_pkg::CNT_W'(sa_pkg::NUM_SLOTS))
                     ? sa_pkg::CNT_W'(sa_pkg::NUM_SLOTS) : cfg.slot_limit;
    assign eff_sz  = (cfg.slot_bytes > sa_pkg::SZ_MAX) ? sa_pkg::SZ_MAX : cfg.slot_bytes;

    // Shared multiplier: limit times size for the range check, or the found
    // slot times size for the find result. Operands are registers, product registered.
    assign mul_a = (r_func == sa_pkg::FN_FIND) ? sa_pkg::CNT_W'(r_slot) : eff_lim;

    always_ff @(posedge i_clk) begin
        r_prod <= sa_pkg::MUL_W'(mul_a) * sa_pkg::MUL_W'(eff_sz);
    end

    // Request check: type, block id, sign, non-zero size and position below the range.
    assign req_ok = (r_obj_type == cfg.ref_type) && (r_blob_id == cfg.ref_blob)
                    && !r_position[sa_pkg::POS_W-1] && (eff_sz != '0)
                    && (r_position[sa_pkg::POS_W-2:0] < (sa_pkg::POS_W-1)'(r_prod));
    assign div_start = (r_state == S_RANGE) && req_ok;

    // Position to slot division.
    sa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (r_position[sa_pkg::DVD_W-1:0]),
        .i_dvs   (eff_sz),
        .o_res   (div_res)
    );

    // Used map store, one row of slots per entry.
    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_MOD) && mod_write);
    assign ram_addr  = ((r_state == S_CLEAR) || (r_state == S_SCAN_RD))
                       ? r_row : r_slot[sa_pkg::SLOT_W-1:sa_pkg::BIT_W];
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : mod_row;

    sa_ram #(
        .WIDTH (sa_pkg::ROW_W),
        .DEPTH (sa_pkg::ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Scan check: free slots of the row read that lie in [r_lo, r_hi).
    always_comb begin
        logic [sa_pkg::CNT_W-1:0] slot_num;
        logic [sa_pkg::CNT_W-1:0] row_base;
        logic [sa_pkg::CNT_W:0]   next_base;
        row_base = sa_pkg::CNT_W'({r_row, {sa_pkg::BIT_W{1'b0}}});
        for (int b = 0; b < sa_pkg::ROW_W; b++) begin
            slot_num  = row_base + sa_pkg::CNT_W'(b);
            free_m[b] = (slot_num >= r_lo) && (slot_num < r_hi) && !ram_rdata[b];
        end
        free_iso = free_m & (~free_m + sa_pkg::ROW_W'(1));
        for (int k = 0; k < sa_pkg::BIT_W; k++) begin
            hit_idx[k] = 1'b0;
            for (int b = 0; b < sa_pkg::ROW_W; b++) begin
                if (((b >> k) & 1) == 1) begin
                    hit_idx[k] = hit_idx[k] | free_iso[b];
                end
            end
        end
        scan_hit  = (free_m != '0);
        next_base = (sa_pkg::CNT_W+1)'(row_base) + (sa_pkg::CNT_W+1)'(sa_pkg::ROW_W);
        scan_last = (next_base >= (sa_pkg::CNT_W+1)'(r_hi));
    end

    // Read-modify-write decision for test, allocate and release.
    always_comb begin
        cur_bit    = ram_rdata[r_slot[sa_pkg::BIT_W-1:0]];
        mod_write  = 1'b0;
        mod_status = sa_pkg::ST_OK;
        n_count    = r_count;
        mod_row    = ram_rdata;
        mod_row[r_slot[sa_pkg::BIT_W-1:0]] = (r_func == sa_pkg::FN_ALLOC);
        case (r_func)
            sa_pkg::FN_TEST: begin
                if (r_count >= eff_lim) begin
                    mod_status = sa_pkg::ST_NOSPACE;
                end else if (cur_bit) begin
                    mod_status = sa_pkg::ST_NOTFOUND;
                end
            end
            sa_pkg::FN_ALLOC: begin
                if (r_count >= eff_lim) begin
                    mod_status = sa_pkg::ST_NOSPACE;
                end else if (cur_bit) begin
                    mod_status = sa_pkg::ST_NOTFOUND;
                end else begin
                    mod_write = 1'b1;
                    n_count   = r_count + sa_pkg::CNT_W'(1);
                end
            end
            sa_pkg::FN_RELEASE: begin
                if ((r_count == '0) || !cur_bit) begin
                    mod_status = sa_pkg::ST_NOTFOUND;
                end else begin
                    mod_write = 1'b1;
                    n_count   = r_count - sa_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, count and result register. Only one request is in work, so the
    // read and write-back of a row never overlap with another access to it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_count     <= '0;
            r_pass      <= 1'b0;
            r_func      <= sa_pkg::FN_FIND;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result word frees the register unless a new one is loaded now.
            if (r_out_valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_row <= r_row + sa_pkg::ROW_IDX_W'(1);
                    if (r_row == sa_pkg::ROW_IDX_W'(sa_pkg::ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func     <= i_req.func;
                        r_position <= i_req.position;
                        r_obj_type <= i_req.obj_type;
                        r_blob_id  <= i_req.blob_id;
                        r_fpos     <= '1;
                        if (i_req.func == sa_pkg::FN_FIND) begin
                            if (r_count >= eff_lim) begin
                                r_status <= sa_pkg::ST_NOSPACE;
                                r_state  <= S_RESP;
                            end else begin
                                r_status <= sa_pkg::ST_OK;
                                r_row    <= r_count[sa_pkg::SLOT_W-1:sa_pkg::BIT_W];
                                r_lo     <= r_count;
                                r_hi     <= eff_lim;
                                r_pass   <= 1'b0;
                                r_state  <= S_SCAN_RD;
                            end
                        end else begin
                            r_status <= sa_pkg::ST_OK;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_RANGE;
                end
                S_RANGE: begin
                    if (req_ok) begin
                        r_state <= S_DIV;
                    end else begin
                        r_status <= sa_pkg::ST_INVALID;
                        r_state  <= S_RESP;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        if (div_res.exact) begin
                            r_slot  <= div_res.quot;
                            r_state <= S_RD;
                        end else begin
                            r_status <= sa_pkg::ST_INVALID;
                            r_state  <= S_RESP;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_status <= mod_status;
                    r_count  <= n_count;
                    r_state  <= S_RESP;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (scan_hit) begin
                        r_slot  <= {r_row, hit_idx};
                        r_state <= S_FMUL;
                    end else if (!scan_last) begin
                        r_row   <= r_row + sa_pkg::ROW_IDX_W'(1);
                        r_state <= S_SCAN_RD;
                    end else if (!r_pass && (r_count != '0)) begin
                        // Wrap: scan from slot zero up to the used count.
                        r_pass  <= 1'b1;
                        r_row   <= '0;
                        r_lo    <= '0;
                        r_hi    <= r_count;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_status <= sa_pkg::ST_NOSPACE;
                        r_state  <= S_RESP;
                    end
                end
                S_FMUL: begin
                    r_state <= S_FPOS;
                end
                S_FPOS: begin
                    r_fpos  <= r_prod[sa_pkg::OUT_POS_W-1:0];
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_pos    <= r_fpos;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.found_position = $signed(r_out_pos);
    assign o_rsp.used_count     = r_out_count;

    // The used count never exceeds the number of slots.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sa_pkg::CNT_W'(sa_pkg::NUM_SLOTS))
        else $error("used count above slot count");

    // The used count only moves in the read-modify-write step.
    a_count_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> ($past(r_state) == S_MOD))
        else $error("used count changed outside the modify step");

    // The divider only reports while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide wait");

endmodule

`default_nettype wire

// File: rtl/sa_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none

module sa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read of the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/sa_div.sv
// Bit-serial restoring divider that turns a byte position into a slot number.
`default_nettype none

module sa_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [sa_pkg::DVD_W-1:0] i_dvd,
    input  wire logic [sa_pkg::SZ_W-1:0]  i_dvs,
    output sa_pkg::t_div_res              o_res
);

    logic                             r_busy;
    logic                             r_done;
    logic [sa_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [sa_pkg::DVD_W-1:0]         r_rem;
    logic [sa_pkg::DVD_W-1:0]         r_dsh;
    logic [sa_pkg::SLOT_W-1:0]        r_quot;
    logic                             ge;

    // The quotient is known to stay below the slot count, so only that many
    // quotient bits are produced, one per cycle from the top.
    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sa_pkg::DIV_CNT_W'(sa_pkg::SLOT_W - 1);
                r_rem  <= i_dvd;
                r_dsh  <= sa_pkg::DVD_W'(i_dvs) << (sa_pkg::SLOT_W - 1);
                r_quot <= '0;
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh  <= r_dsh >> 1;
                r_quot <= {r_quot[sa_pkg::SLOT_W-2:0], ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - sa_pkg::DIV_CNT_W'(1);
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.exact = (r_rem == '0);
    assign o_res.quot  = r_quot;

endmodule

`default_nettype wire

// File: rtl/sa_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module sa_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sa_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sa_pkg::PDATA_W-1:0] pwdata,
    output logic [sa_pkg::PDATA_W-1:0]      prdata,
    output logic                            pready,
    output sa_pkg::t_cfg                    o_cfg
);

    sa_pkg::t_cfg                  r_cfg;
    logic [sa_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                          wr_en;

    // Registers sit on 8-byte boundaries.
    assign reg_idx = paddr[sa_pkg::PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_bytes <= sa_pkg::SLOT_BYTES_RST;
            r_cfg.slot_limit <= '0;
            r_cfg.ref_type   <= '0;
            r_cfg.ref_blob   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                sa_pkg::REG_SLOT_BYTES: r_cfg.slot_bytes <= pwdata[sa_pkg::SZ_W-1:0];
                sa_pkg::REG_SLOT_LIMIT: r_cfg.slot_limit <= pwdata[sa_pkg::CNT_W-1:0];
                sa_pkg::REG_REF_TYPE:   r_cfg.ref_type   <= pwdata[sa_pkg::TYPE_W-1:0];
                sa_pkg::REG_REF_BLOB:   r_cfg.ref_blob   <= pwdata[sa_pkg::BLOB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        case (reg_idx)
            sa_pkg::REG_SLOT_BYTES: prdata = sa_pkg::PDATA_W'(r_cfg.slot_bytes);
            sa_pkg::REG_SLOT_LIMIT: prdata = sa_pkg::PDATA_W'(r_cfg.slot_limit);
            sa_pkg::REG_REF_TYPE:   prdata = sa_pkg::PDATA_W'(r_cfg.ref_type);
            sa_pkg::REG_REF_BLOB:   prdata = sa_pkg::PDATA_W'(r_cfg.ref_blob);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: test/slot_allocator_with_state_map_core_tb.sv
// Self-checking testbench of the slot allocator core: APB set-up, random requests, checked words.
module slot_allocator_with_state_map_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sa_pkg::*;

    // Cycles without any accepted word before the run is abandoned.
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [TYPE_W-1:0] obj_type;
        logic [BLOB_W-1:0] blob_id;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_POS_W-1:0] found_position;
        logic [CNT_W-1:0]     used_count;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    sa_req_if req_ch();
    sa_rsp_if rsp_ch();

    slot_allocator_with_state_map_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the register file and of the used map.
    logic [SZ_W-1:0]   cfg_size  = SLOT_BYTES_RST;
    logic [CNT_W-1:0]  cfg_limit = '0;
    logic [TYPE_W-1:0] cfg_type  = '0;
    logic [BLOB_W-1:0] cfg_blob  = '0;
    bit               slot_taken [NUM_SLOTS];
    logic [CNT_W-1:0] taken_count = '0;

    t_request pending_reqs[$];
    t_outcome expected_outcomes[$];
    t_request in_flight;
    t_outcome want;
    int n_sent      = 0;
    int n_mismatch  = 0;
    int stall_count = 0;

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int unsigned eff_limit();
        return (cfg_limit > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_limit);
    endfunction

    function automatic longint unsigned eff_size();
        return (cfg_size > SZ_MAX) ? longint'(SZ_MAX) : longint'(cfg_size);
    endfunction

    // Works out the result word of one request and updates the mirrored map.
    function automatic t_outcome predict_outcome(input t_request r);
        t_outcome o;
        int unsigned lim;
        longint unsigned sz;
        longint unsigned pos;
        int unsigned slot;
        bit hit;
        lim = eff_limit();
        sz = eff_size();
        pos = 64'(r.position);
        o.status = ST_OK;
        o.found_position = '1;
        slot = 0;
        hit = 1'b0;
        if (r.func == FN_FIND) begin
            // Scan from the used count upwards, then wrap round from slot zero.
            for (int unsigned s = taken_count; s < lim && !hit; s++) begin
                if (!slot_taken[s]) begin
                    slot = s;
                    hit = 1'b1;
                end
            end
            for (int unsigned s = 0; s < taken_count && s < lim && !hit; s++) begin
                if (!slot_taken[s]) begin
                    slot = s;
                    hit = 1'b1;
                end
            end
            if (taken_count >= lim || !hit) begin
                o.status = ST_NOSPACE;
            end else begin
                o.found_position = OUT_POS_W'(slot * sz);
            end
        end else if (r.obj_type != cfg_type || r.blob_id != cfg_blob || r.position[POS_W-1]
                     || sz == 0 || pos >= lim * sz || pos % sz != 0) begin
            o.status = ST_INVALID;
        end else begin
            slot = int'(pos / sz);
            case (r.func)
                FN_TEST: begin
                    if (taken_count >= lim) o.status = ST_NOSPACE;
                    else if (slot_taken[slot]) o.status = ST_NOTFOUND;
                end
                FN_ALLOC: begin
                    if (taken_count >= lim) begin
                        o.status = ST_NOSPACE;
                    end else if (slot_taken[slot]) begin
                        o.status = ST_NOTFOUND;
                    end else begin
                        slot_taken[slot] = 1'b1;
                        taken_count = taken_count + 1'b1;
                    end
                end
                default: begin
                    if (taken_count == 0 || !slot_taken[slot]) begin
                        o.status = ST_NOTFOUND;
                    end else begin
                        slot_taken[slot] = 1'b0;
                        taken_count = taken_count - 1'b1;
                    end
                end
            endcase
        end
        o.used_count = taken_count;
        return o;
    endfunction

    // Idling shares: sender busier first, then the receiver, then neither idles.
    function automatic int send_idle_pct();
        return (n_sent < 360) ? 29 : (n_sent < 720) ? 52 : 0;
    endfunction

    function automatic int drain_idle_pct();
        return (n_sent < 360) ? 52 : (n_sent < 720) ? 29 : 0;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want_v, got_v);
    endtask

    // Request driver: a word stays on the channel until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_outcomes.push_back(predict_outcome(in_flight));
                n_sent++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    in_flight = pending_reqs.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.func     <= in_flight.func;
                    req_ch.position <= in_flight.position;
                    req_ch.obj_type <= in_flight.obj_type;
                    req_ch.blob_id  <= in_flight.blob_id;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: each taken word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_outcomes.size() == 0) begin
                    flag_mismatch("unexpected result word", 0, rsp_ch.status);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (rsp_ch.status !== want.status)
                        flag_mismatch("status", want.status, rsp_ch.status);
                    if (rsp_ch.found_position !== want.found_position)
                        flag_mismatch("found_position", want.found_position,
                                      rsp_ch.found_position);
                    if (rsp_ch.used_count !== want.used_count)
                        flag_mismatch("used_count", want.used_count, rsp_ch.used_count);
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= drain_idle_pct());
        end
    end

    // Watchdog on cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle until pready is seen.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SLOT_BYTES: cfg_size  = value[SZ_W-1:0];
            REG_SLOT_LIMIT: cfg_limit = value[CNT_W-1:0];
            REG_REF_TYPE:   cfg_type  = value[TYPE_W-1:0];
            default:        cfg_blob  = value[BLOB_W-1:0];
        endcase
    endtask

    task automatic queue_req(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] position,
                             input logic [TYPE_W-1:0] obj_type, input logic [BLOB_W-1:0] blob_id);
        t_request r;
        r.func = func;
        r.position = position;
        r.obj_type = obj_type;
        r.blob_id = blob_id;
        pending_reqs.push_back(r);
    endtask

    // Blocks until every queued word is taken and every result has come back.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Random requests: mostly well formed for the present set-up, the rest broken.
    task automatic gen_items(input int n, input int alloc_pct);
        t_request r;
        int unsigned lim;
        longint unsigned sz;
        int unsigned slot;
        lim = eff_limit();
        sz = eff_size();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                r.func = FN_ALLOC;
            end else begin
                case ($urandom_range(0, 2))
                    0:       r.func = FN_FIND;
                    1:       r.func = FN_TEST;
                    default: r.func = FN_RELEASE;
                endcase
            end
            slot = (lim != 0) ? $urandom_range(0, lim - 1) : 0;
            r.position = POS_W'(slot * sz);
            r.obj_type = cfg_type;
            r.blob_id = cfg_blob;
            if ($urandom_range(0, 99) < 20) begin
                case ($urandom_range(0, 5))
                    0: begin
                        r.func = FUNC_W'($urandom_range(0, 3));
                        r.position = POS_W'({$urandom(), $urandom()});
                        r.obj_type = TYPE_W'($urandom());
                        r.blob_id = {$urandom(), $urandom()};
                    end
                    1: r.obj_type = r.obj_type ^ TYPE_W'($urandom_range(1, 255));
                    2: r.blob_id = r.blob_id ^ (64'd1 << $urandom_range(0, 63));
                    3: r.position = {1'b1, 40'({$urandom(), $urandom()})};
                    4: begin
                        if (sz > 1)
                            r.position = r.position
                                         + POS_W'($urandom_range(1, 32'(sz - 1)));
                    end
                    default: r.position = POS_W'(lim * sz + sz * $urandom_range(0, 3));
                endcase
            end
            pending_reqs.push_back(r);
        end
    endtask

    // One set-up: every register written while idle, then a batch of requests.
    task automatic run_phase(input logic [SZ_W-1:0] size, input logic [CNT_W-1:0] limit,
                             input logic [TYPE_W-1:0] rtype, input logic [BLOB_W-1:0] blob,
                             input int n, input int alloc_pct);
        wait_drained();
        reg_write(REG_SLOT_BYTES, PDATA_W'(size));
        reg_write(REG_SLOT_LIMIT, PDATA_W'(limit));
        reg_write(REG_REF_TYPE, PDATA_W'(rtype));
        reg_write(REG_REF_BLOB, blob);
        gen_items(n, alloc_pct);
        wait_drained();
    endtask

    // Stimulus sequence.
    initial begin
        logic [TYPE_W-1:0] t;
        logic [BLOB_W-1:0] b;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FN_FIND;
        req_ch.position = '0;
        req_ch.obj_type = '0;
        req_ch.blob_id = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: 64-byte slots, eight of them.
        t = 8'hA5;
        b = {$urandom(), $urandom()};
        reg_write(REG_SLOT_BYTES, PDATA_W'(64));
        reg_write(REG_SLOT_LIMIT, PDATA_W'(8));
        reg_write(REG_REF_TYPE, PDATA_W'(t));
        reg_write(REG_REF_BLOB, b);
        queue_req(FN_RELEASE, '0, t, b);             // release with nothing in use
        queue_req(FN_FIND, '0, t, b);
        queue_req(FN_TEST, '0, t, b);
        queue_req(FN_ALLOC, '0, t, b);
        queue_req(FN_ALLOC, '0, t, b);               // slot already taken
        queue_req(FN_TEST, '0, t, b);
        queue_req(FN_RELEASE, POS_W'(64), t, b);     // slot already free
        queue_req(FN_ALLOC, POS_W'(64), ~t, b);      // wrong object type
        queue_req(FN_ALLOC, POS_W'(64), t, ~b);      // wrong block id
        queue_req(FN_ALLOC, 41'h100_0000_0000, t, b); // most negative position
        queue_req(FN_TEST, 41'h0FF_FFFF_FFFF, t, b);  // largest positive position
        queue_req(FN_ALLOC, POS_W'(65), t, b);       // misaligned
        queue_req(FN_ALLOC, POS_W'(512), t, b);      // just past the limit
        for (int s = 1; s < 8; s++)
            queue_req(FN_ALLOC, POS_W'(s * 64), t, b);
        queue_req(FN_ALLOC, POS_W'(128), t, b);      // map full
        queue_req(FN_FIND, '0, t, b);
        queue_req(FN_TEST, '0, t, b);
        queue_req(FN_RELEASE, POS_W'(192), t, b);
        queue_req(FN_FIND, '0, t, b);                // scan has to wrap round
        wait_drained();

        // Random part over several set-ups, extremes included.
        run_phase(SZ_W'(4096), CNT_W'(16), TYPE_W'($urandom()), {$urandom(), $urandom()},
                  150, 45);
        run_phase(SZ_W'(1), CNT_W'(4096), 8'h00, 64'd0, 120, 40);
        run_phase(SZ_MAX, 13'h1FFF, 8'hFF, '1, 120, 40);
        run_phase(21'h1F_FFFF, CNT_W'(33), TYPE_W'($urandom()), {$urandom(), $urandom()},
                  120, 45);
        t = TYPE_W'($urandom());
        b = {$urandom(), $urandom()};
        run_phase(SZ_W'(512), CNT_W'(40), t, b, 150, 60);
        run_phase(SZ_W'(512), CNT_W'(5), t, b, 80, 30);   // limit now below the used count
        run_phase('0, CNT_W'(64), TYPE_W'($urandom()), {$urandom(), $urandom()}, 40, 40);
        run_phase(SZ_W'(8), '0, TYPE_W'($urandom()), {$urandom(), $urandom()}, 40, 40);
        run_phase(SZ_W'(3), CNT_W'(100), TYPE_W'($urandom()), {$urandom(), $urandom()},
                  150, 50);
        run_phase(SZ_W'($urandom_range(1, 2097151)), CNT_W'($urandom_range(1, 200)),
                  TYPE_W'($urandom()), {$urandom(), $urandom()}, 100, 45);

        // Let any stray word show up before the verdict.
        repeat (300) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
